>>> rtl/dnpt_pkg.sv
// ----------------------------------------------------------------------------
// dnpt_pkg
// Shared types and constants for the day/night pump cycle timer.
// ----------------------------------------------------------------------------
`default_nettype none

package dnpt_pkg;

    // Field widths
    localparam int unsigned MIN_W   = 11;  // minute of day, on/off minutes
    localparam int unsigned HOURS_W = 5;
    localparam int unsigned CYC_W   = 12;  // on + off, lead minutes
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned CFG_W   = 12;  // widest register
    localparam int unsigned IDX_W   = 3;

    // Calendar constants
    localparam logic [CYC_W-1:0]   MINUTES_PER_DAY = 12'd1440;
    localparam logic [HOURS_W-1:0] MAX_DAY_HOURS   = 5'd24;

    // Remainder unit: one quotient bit per cycle over the offset word
    localparam int unsigned DIV_STEPS = MIN_W;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

    // Register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_DAY_START   = 3'd0,
        REG_DAY_HOURS   = 3'd1,
        REG_DAY_ON      = 3'd2,
        REG_DAY_OFF     = 3'd3,
        REG_NIGHT_ON    = 3'd4,
        REG_NIGHT_OFF   = 3'd5,
        REG_BLOWER_MODE = 3'd6,
        REG_AIR_LEAD    = 3'd7
    } t_reg_idx;

    // Air pump modes
    typedef enum logic [MODE_W-1:0] {
        AIR_ALWAYS = 2'd0,
        AIR_FOLLOW = 2'd1,
        AIR_LEAD   = 2'd2,
        AIR_OFF    = 2'd3
    } t_blower_mode;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PHASE,
        S_OFFSET,
        S_DIV,
        S_DONE
    } t_state;

    // Request to the remainder unit
    typedef struct packed {
        logic             start;
        logic [MIN_W-1:0] dividend;
        logic [CYC_W-1:0] divisor;
    } t_div_req;

    // Response from the remainder unit
    typedef struct packed {
        logic             done;
        logic [MIN_W-1:0] rem;
    } t_div_rsp;

endpackage

`default_nettype wire

>>> rtl/dnpt_in_if.sv
// ----------------------------------------------------------------------------
// dnpt_in_if
// Minute tick channel: valid/ready with the tick payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface dnpt_in_if;
    import dnpt_pkg::*;

    logic             valid;
    logic             ready;
    logic [MIN_W-1:0] minute_of_day;
    logic             tank_low;
    logic             maintenance;

    modport source (output valid, output minute_of_day, output tank_low,
                    output maintenance, input ready);
    modport sink   (input valid, input minute_of_day, input tank_low,
                    input maintenance, output ready);
endinterface

`default_nettype wire

>>> rtl/dnpt_out_if.sv
// ----------------------------------------------------------------------------
// dnpt_out_if
// Pump command channel: valid/ready with the result payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface dnpt_out_if;
    logic valid;
    logic ready;
    logic water_on;
    logic air_on;
    logic is_day;
    logic changed;

    modport source (output valid, output water_on, output air_on,
                    output is_day, output changed, input ready);
    modport sink   (input valid, input water_on, input air_on,
                    input is_day, input changed, output ready);
endinterface

`default_nettype wire

>>> rtl/day_night_pump_cycle_timer_core.sv
// ----------------------------------------------------------------------------
// day_night_pump_cycle_timer_core
// Per-minute pump scheduler: day/night phase, position in the on/off cycle,
// water and air pump commands with forced-off handling.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake       Payload
//  i_in     in   valid/ready     minute_of_day, tank_low, maintenance
//  o_out    out  valid/ready     water_on, air_on, is_day, changed
//  i_cfg_*  in   write enable    index, 12-bit data
//
//  A tick passes from acceptance to the result register through the PHASE
//  and OFFSET set-up states, the remainder unit (one step per dividend bit)
//  and the DONE state. One tick is in flight at a time.
//  Ready stays low until the result is loaded into the output register.
//  A stalled output holds the sequencer in its last state.
//  Reset is synchronous, active low; control, configuration and pump state
//  registers clear to zero, datapath registers are loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

module day_night_pump_cycle_timer_core
    import dnpt_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    dnpt_in_if.sink              i_in,
    dnpt_out_if.source           o_out,
    input  wire                  i_cfg_we,
    input  wire [IDX_W-1:0]      i_cfg_idx,
    input  wire [CFG_W-1:0]      i_cfg_data
);

    // Configuration registers
    logic [MIN_W-1:0]   r_day_start;
    logic [HOURS_W-1:0] r_day_hours;
    logic [MIN_W-1:0]   r_day_on;
    logic [MIN_W-1:0]   r_day_off;
    logic [MIN_W-1:0]   r_night_on;
    logic [MIN_W-1:0]   r_night_off;
    t_blower_mode       r_blower_mode;
    logic [CYC_W-1:0]   r_air_lead;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day_start   <= '0;
            r_day_hours   <= '0;
            r_day_on      <= '0;
            r_day_off     <= '0;
            r_night_on    <= '0;
            r_night_off   <= '0;
            r_blower_mode <= AIR_ALWAYS;
            r_air_lead    <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_DAY_START:   r_day_start <= i_cfg_data[MIN_W-1:0];
                REG_DAY_HOURS:   r_day_hours <= i_cfg_data[HOURS_W-1:0];
                REG_DAY_ON:      r_day_on    <= i_cfg_data[MIN_W-1:0];
                REG_DAY_OFF:     r_day_off   <= i_cfg_data[MIN_W-1:0];
                REG_NIGHT_ON:    r_night_on  <= i_cfg_data[MIN_W-1:0];
                REG_NIGHT_OFF:   r_night_off <= i_cfg_data[MIN_W-1:0];
                REG_BLOWER_MODE: r_blower_mode <= t_blower_mode'(i_cfg_data[MODE_W-1:0]);
                REG_AIR_LEAD:    r_air_lead  <= i_cfg_data[CYC_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer state and control outputs
    t_state   r_state;
    t_state   n_state;
    logic     in_take;
    logic     out_free;
    logic     out_load;
    logic     div_start;
    t_div_req div_req;
    t_div_rsp div_rsp;

    assign out_free = !o_out.valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in.valid) n_state = S_PHASE;
            S_PHASE:  n_state = S_OFFSET;
            S_OFFSET: n_state = S_DIV;
            S_DIV:    if (div_rsp.done) n_state = S_DONE;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            S_IDLE:   i_in.ready = 1'b1;
            S_OFFSET: div_start  = 1'b1;
            S_DONE:   out_load   = out_free;
            default: ;
        endcase
    end

    assign in_take = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Capture the tick, minute folded into one day
    logic [MIN_W-1:0] r_cur;
    logic             r_forced;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cur    <= ({1'b0, i_in.minute_of_day} >= MINUTES_PER_DAY)
                        ? MIN_W'({1'b0, i_in.minute_of_day} - MINUTES_PER_DAY)
                        : i_in.minute_of_day;
            r_forced <= i_in.tank_low || i_in.maintenance;
        end
    end

    // Phase decision: day window, start of the current phase
    logic [MIN_W-1:0]   start_m;
    logic [HOURS_W-1:0] hours;
    logic [MIN_W-1:0]   dur;
    logic [CYC_W-1:0]   end_m;
    logic               wraps;
    logic [MIN_W-1:0]   end_fold;
    logic               day;
    logic               r_day;
    logic [MIN_W-1:0]   r_phase_start;

    always_comb begin
        start_m  = ({1'b0, r_day_start} >= MINUTES_PER_DAY)
                   ? MIN_W'({1'b0, r_day_start} - MINUTES_PER_DAY) : r_day_start;
        hours    = (r_day_hours > MAX_DAY_HOURS) ? MAX_DAY_HOURS : r_day_hours;
        // hours * 60 as 64h - 4h
        dur      = MIN_W'({hours, 6'b0}) - MIN_W'({hours, 2'b0});
        end_m    = {1'b0, start_m} + {1'b0, dur};
        wraps    = (end_m >= MINUTES_PER_DAY);
        end_fold = wraps ? MIN_W'(end_m - MINUTES_PER_DAY) : end_m[MIN_W-1:0];
        if (!wraps) day = (r_cur >= start_m) && ({1'b0, r_cur} < end_m);
        else        day = (r_cur >= start_m) || (r_cur < end_fold);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PHASE) begin
            r_day         <= day;
            r_phase_start <= day ? start_m : end_fold;
        end
    end

    // Offset into the phase and the phase's cycle length
    logic [CYC_W-1:0] off_raw;
    logic [CYC_W-1:0] cycle;
    logic [MIN_W-1:0] on_sel;
    logic [CYC_W-1:0] r_total;
    logic [MIN_W-1:0] r_on;

    always_comb begin
        off_raw = {1'b0, r_cur} - {1'b0, r_phase_start};
        if (r_cur < r_phase_start) off_raw = off_raw + MINUTES_PER_DAY;
        on_sel  = r_day ? r_day_on : r_night_on;
        cycle   = {1'b0, on_sel} + {1'b0, (r_day ? r_day_off : r_night_off)};
        div_req.start    = div_start;
        div_req.dividend = off_raw[MIN_W-1:0];
        div_req.divisor  = cycle;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OFFSET) begin
            r_total <= cycle;
            r_on    <= on_sel;
        end
    end

    dnpt_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Pump decision from the position in the cycle
    logic             unconf;
    logic             water_new;
    logic             air_new;
    logic [CYC_W-1:0] pos;

    always_comb begin
        unconf    = (r_day_on == '0 && r_day_off == '0) ||
                    (r_night_on == '0 && r_night_off == '0);
        pos       = {1'b0, div_rsp.rem};
        water_new = 1'b0;
        air_new   = 1'b0;
        if (!r_forced && !unconf) begin
            water_new = (div_rsp.rem < r_on);
            case (r_blower_mode)
                AIR_ALWAYS: air_new = 1'b1;
                AIR_FOLLOW: air_new = water_new;
                AIR_LEAD: begin
                    if (r_air_lead >= r_total || r_air_lead == '0)
                        air_new = 1'b1;
                    else
                        air_new = (pos >= r_total - r_air_lead) || water_new;
                end
                default: air_new = 1'b0;
            endcase
        end
    end

    // Pump state and output register
    logic r_water_st;
    logic r_air_st;
    logic r_out_valid;
    logic r_water_on;
    logic r_air_on;
    logic r_is_day;
    logic r_changed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_water_st  <= 1'b0;
            r_air_st    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_water_st  <= water_new;
            r_air_st    <= air_new;
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_water_on <= water_new;
            r_air_on   <= air_new;
            r_is_day   <= r_day;
            r_changed  <= (water_new != r_water_st) || (air_new != r_air_st);
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.water_on = r_water_on;
    assign o_out.air_on   = r_air_on;
    assign o_out.is_day   = r_is_day;
    assign o_out.changed  = r_changed;

endmodule

`default_nettype wire

>>> rtl/dnpt_rem.sv
// ----------------------------------------------------------------------------
// dnpt_rem
// Iterative restoring remainder: one shared compare/subtract per cycle,
// one dividend bit per step; a new start abandons a request in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module dnpt_rem
    import dnpt_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [MIN_W-1:0]  r_dvd;
    logic [MIN_W-1:0]  r_rem;
    logic [CYC_W-1:0]  r_div;

    logic [CYC_W-1:0]  trial;
    logic [CYC_W-1:0]  diff;
    logic              take;
    logic [MIN_W-1:0]  n_rem;

    // Shared subtract and compare
    always_comb begin
        trial = {r_rem, r_dvd[MIN_W-1]};
        diff  = trial - r_div;
        take  = (trial >= r_div);
        n_rem = take ? diff[MIN_W-1:0] : trial[MIN_W-1:0];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[MIN_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

>>> rtl/dnpt_checker.sv
// ----------------------------------------------------------------------------
// dnpt_checker
// Port-level checks on the pump cycle timer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dnpt_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_in_valid,
    input wire i_in_ready,
    input wire i_out_valid,
    input wire i_out_ready,
    input wire i_water_on,
    input wire i_air_on,
    input wire i_is_day,
    input wire i_changed
);

    // Stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_water_on) && $stable(i_air_on) &&
            $stable(i_is_day) && $stable(i_changed))
        else $error("result changed while stalled");

    // One tick at a time: busy right after a transaction
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready ##1 !i_in_ready)
        else $error("accepted a tick while busy");

    // A new result is never loaded while the input side is open
    a_load_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a tick in flight");

    // No result rises too soon after a transaction
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid) ##1 !$rose(i_out_valid))
        else $error("result too early");

endmodule

bind day_night_pump_cycle_timer_core dnpt_checker u_dnpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_water_on  (o_out.water_on),
    .i_air_on    (o_out.air_on),
    .i_is_day    (o_out.is_day),
    .i_changed   (o_out.changed)
);

`default_nettype wire
